FILE: rtl/bal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

  // default configuration
  localparam int unsigned DefArenaBytesLog2  = 34;
  localparam int unsigned DefBlockBytesLog2  = 16;
  localparam int unsigned DefCommitChunkLog2 = 26;
  localparam int unsigned DefNumContexts     = 16;

  // fixed field and state widths
  localparam int unsigned CtxFieldW  = 4;
  localparam int unsigned CtxCodes   = 2 ** CtxFieldW;
  localparam int unsigned SizeW      = 35;
  localparam int unsigned AlignW     = 6;
  localparam int unsigned OffsetW    = 34;
  localparam int unsigned TopW       = 35;
  localparam int unsigned CalcW      = 36;
  localparam int unsigned UnitW      = 32;

  // alignment limits
  localparam logic [AlignW-1:0] MinAlignLog2   = AlignW'(2);
  localparam logic [AlignW-1:0] LocalAlignLog2 = AlignW'(6);

  typedef struct packed {
    logic [CtxFieldW-1:0] context_req;
    logic [SizeW-1:0]     request_bytes;
    logic [AlignW-1:0]    align_log2;
  } req_t;

  typedef struct packed {
    logic [OffsetW-1:0] byte_offset;
    logic               overflow_error;
    logic               commit_valid;
    logic [TopW-1:0]    commit_limit;
  } rsp_t;

  // one local block, in four-byte units
  typedef struct packed {
    logic [UnitW-1:0] pos;
    logic [UnitW-1:0] lim;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/bal_ctx_table.sv
`timescale 1ns / 1ps
`default_nettype none

module bal_ctx_table import bal_pkg::*; #(
  parameter int unsigned NUM_CONTEXTS = DefNumContexts,
  parameter int unsigned CTX_W        = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [CTX_W-1:0] rd_idx_i,
  output      entry_t           rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [CTX_W-1:0] wr_idx_i,
  input  wire entry_t           wr_data_i
);

  entry_t                  mem_q [NUM_CONTEXTS];
  logic [NUM_CONTEXTS-1:0] valid_q;
  entry_t                  rd_q;
  logic                    rd_valid_q;
  logic                    bypass;

  // a read that meets a write to the same entry takes the new data
  assign bypass = wr_en_i && (wr_idx_i == rd_idx_i);

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  // per-entry written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= bypass ? wr_data_i : mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= bypass || valid_q[rd_idx_i];
    end
  end

  // entries never written read as an empty block
  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: rtl/bump_allocator_with_local_blocks.sv
`timescale 1ns / 1ps
`default_nettype none

// Bump-pointer arena allocator with a local block per requester context.
// Request channel: in_valid_i / in_stall_o carrying req_t (context, size,
// log2 alignment). Response channel: out_valid_o / out_stall_i carrying
// rsp_t (byte offset, overflow flag, watermark raise and new watermark).
// Every request gives exactly one response, in order.
// A taken request goes into the request register and the context table is
// read in step with it; its response goes into the response register.
// Throughput: one request per cycle while the receiver does not stall; the
// whole allocation, local block fit or global bump with alignment padding
// and watermark update, is one combinational pass between the two registers.
// Reset clears the global pointer, the committed watermark and the written
// flags of the context table, so every context starts without a block.
// No clearing pass is needed; requests are taken right after reset.
// When the receiver stalls, the response register holds; one more request
// waits in the request register, after which in_stall_o is raised.
// Overflowing requests report an error and leave all state untouched.
module bump_allocator_with_local_blocks import bal_pkg::*; #(
  parameter int unsigned ARENA_BYTES_LOG2  = DefArenaBytesLog2,
  parameter int unsigned BLOCK_BYTES_LOG2  = DefBlockBytesLog2,
  parameter int unsigned COMMIT_CHUNK_LOG2 = DefCommitChunkLog2,
  parameter int unsigned NUM_CONTEXTS      = DefNumContexts
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_stall_o,
  input  wire req_t in_data_i,
  output      logic out_valid_o,
  input  wire logic out_stall_i,
  output      rsp_t out_data_o
);

  localparam int unsigned CtxW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

  localparam logic [CalcW-1:0] ArenaSize  = CalcW'(1) << ARENA_BYTES_LOG2;
  localparam logic [CalcW-1:0] BlockSize  = CalcW'(1) << BLOCK_BYTES_LOG2;
  localparam logic [CalcW-1:0] ChunkMask  = (CalcW'(1) << COMMIT_CHUNK_LOG2) - CalcW'(1);
  localparam logic [SizeW-1:0] LocalMax   = SizeW'(1) << (BLOCK_BYTES_LOG2 - 2);
  localparam logic [CalcW-3:0] BlockUnits = (CalcW-2)'(1) << (BLOCK_BYTES_LOG2 - 2);

  // context code to table row
  logic [CtxW-1:0] ctx_map [CtxCodes];
  for (genvar g = 0; g < CtxCodes; g++) begin : g_ctx_map
    assign ctx_map[g] = CtxW'(g % NUM_CONTEXTS);
  end

  // handshake
  logic            s1_valid_q;
  req_t            s1_req_q;
  logic [CtxW-1:0] s1_ctx_q;
  logic            out_valid_q;
  rsp_t            out_rsp_q;
  logic            in_xfer;
  logic            s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // allocator state
  logic [TopW-1:0] global_top_q;
  logic [TopW-1:0] committed_top_q;

  entry_t ent;
  entry_t wr_ent;
  logic   wr_en;

  bal_ctx_table #(
    .NUM_CONTEXTS(NUM_CONTEXTS),
    .CTX_W       (CtxW)
  ) u_ctx_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_xfer),
    .rd_idx_i (ctx_map[in_data_i.context_req]),
    .rd_data_o(ent),
    .wr_en_i  (wr_en),
    .wr_idx_i (s1_ctx_q),
    .wr_data_i(wr_ent)
  );

  // request decode
  logic [AlignW-1:0] lg_eff;
  logic              local_req;
  logic [UnitW:0]    size4;
  logic [2:0]        loc_sh;
  logic [UnitW:0]    a4m;
  logic [UnitW:0]    pos33;
  logic [UnitW:0]    lim33;
  logic [UnitW:0]    b4;
  logic              fit;

  assign lg_eff = (s1_req_q.align_log2 < MinAlignLog2) ? MinAlignLog2 : s1_req_q.align_log2;
  assign local_req = (s1_req_q.request_bytes <= LocalMax) && (lg_eff <= LocalAlignLog2);
  assign size4  = (UnitW+1)'((CalcW'(s1_req_q.request_bytes) + CalcW'(3)) >> 2);

  // local block fit, in four-byte units
  assign loc_sh = 3'(lg_eff - MinAlignLog2);
  assign a4m    = (UnitW+1)'((5'd1 << loc_sh) - 5'd1);
  assign pos33  = (UnitW+1)'(ent.pos);
  assign lim33  = (UnitW+1)'(ent.lim);
  assign b4     = (pos33 + a4m) & ~a4m;
  assign fit    = (ent.pos != '0) && (b4 <= lim33) && (size4 <= lim33 - b4);

  // global bump
  logic              need_global;
  logic [CalcW-1:0]  g_size;
  logic [AlignW-1:0] g_lg;
  logic [CalcW-1:0]  old;
  logic [CalcW-1:0]  amask;
  logic [CalcW-1:0]  pad;
  logic [CalcW-1:0]  rem;
  logic              g_ok;
  logic [CalcW-1:0]  gb;
  logic [CalcW-1:0]  ge;
  logic [CalcW-1:0]  next_commit;
  logic              raise;
  logic              ok;

  assign need_global = !local_req || !fit;
  assign g_size      = local_req ? BlockSize : CalcW'(s1_req_q.request_bytes);
  assign g_lg        = local_req ? LocalAlignLog2 : lg_eff;
  assign old         = CalcW'(global_top_q);
  assign amask       = (CalcW'(1) << g_lg) - CalcW'(1);
  assign pad         = (CalcW'(0) - old) & amask;
  assign rem         = ArenaSize - old;
  assign g_ok        = (old <= ArenaSize) && (pad <= rem) && (g_size <= rem - pad);
  assign gb          = old + pad;
  assign ge          = gb + g_size;
  assign next_commit = (ge + ChunkMask) & ~ChunkMask;
  assign raise       = need_global && g_ok && (ge > CalcW'(committed_top_q));
  assign ok          = (local_req && fit) || g_ok;

  // local block update
  logic [CalcW-3:0] gb4;
  logic [CalcW-3:0] gpos;
  logic [CalcW-3:0] glim;
  logic [UnitW:0]   lpos;

  assign gb4  = gb[CalcW-1:2];
  assign gpos = gb4 + (CalcW-2)'(size4);
  assign glim = gb4 + BlockUnits;
  assign lpos = b4 + size4;

  assign wr_en      = s1_adv && local_req && ok;
  assign wr_ent.pos = fit ? lpos[UnitW-1:0] : gpos[UnitW-1:0];
  assign wr_ent.lim = fit ? ent.lim : glim[UnitW-1:0];

  // response
  rsp_t             rsp;
  logic [CalcW-1:0] begin_off;

  assign begin_off          = (local_req && fit) ? CalcW'({b4, 2'b00}) : gb;
  assign rsp.byte_offset    = ok ? begin_off[OffsetW-1:0] : '0;
  assign rsp.overflow_error = !ok;
  assign rsp.commit_valid   = raise;
  assign rsp.commit_limit   = raise ? next_commit[TopW-1:0] : '0;

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_xfer || (s1_valid_q && !s1_adv);
      out_valid_q <= s1_adv || (out_valid_q && out_stall_i);
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q <= in_data_i;
      s1_ctx_q <= ctx_map[in_data_i.context_req];
    end
    if (s1_adv) begin
      out_rsp_q <= rsp;
    end
  end

  // global pointer and committed watermark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_top_q    <= '0;
      committed_top_q <= '0;
    end else if (s1_adv && need_global && g_ok) begin
      global_top_q <= ge[TopW-1:0];
      if (raise) begin
        committed_top_q <= next_commit[TopW-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_rsp_q;

endmodule

`default_nettype wire

FILE: rtl/bal_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bal_checker import bal_pkg::*; #(
  parameter int unsigned COMMIT_CHUNK_LOG2 = DefCommitChunkLog2
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire rsp_t out_data_o
);

  localparam logic [TopW-1:0] ChunkMask = (TopW'(1) << COMMIT_CHUNK_LOG2) - TopW'(1);

  // a stalled response transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");

  // with the response register empty the request side never stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty response register");

  // an overflow leaves every other field clear
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow_error |->
      out_data_o.byte_offset == '0 && !out_data_o.commit_valid &&
      out_data_o.commit_limit == '0)
    else $error("overflow response carries data");

  // a raised watermark sits on a nonzero chunk boundary
  a_commit_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.commit_valid |->
      (out_data_o.commit_limit & ChunkMask) == '0 && out_data_o.commit_limit != '0)
    else $error("watermark not on a chunk boundary");

  // no watermark without a raise
  a_commit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.commit_valid |-> out_data_o.commit_limit == '0)
    else $error("watermark reported without a raise");

endmodule

bind bump_allocator_with_local_blocks bal_checker #(
  .COMMIT_CHUNK_LOG2(COMMIT_CHUNK_LOG2)
) u_bal_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
